@@ src/butterworth_lowpass_filter_unit_macros.svh @@
// assertion macros for the butterworth low-pass filter unit
// used by the checker; no other dependencies
`ifndef BUTTERWORTH_LOWPASS_FILTER_UNIT_MACROS_SVH
`define BUTTERWORTH_LOWPASS_FILTER_UNIT_MACROS_SVH

// checked only while out of reset
`define BWLF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BWLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bwlf_pkg.sv @@
// shared types and constants of the butterworth low-pass filter unit
// no dependencies
package bwlf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DT_W     = 20;
    localparam int CUT_W    = 24;
    localparam int ORD_W    = 2;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int HIST_W   = 32;
    localparam int COEF_W   = 32;
    localparam int ALPHA_W  = 31;
    localparam int WIDE_W   = 63;
    localparam int ACC_W    = 68;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    // 2*pi scaled for the alpha product, and 2*sqrt(2) in q2.30
    localparam logic [31:0] ALPHA_K      = 32'd1768559438;
    localparam logic [31:0] TWO_SQRT2_Q30 = 32'd3037000500;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd3;

    localparam logic [ORD_W-1:0] ORDER_ONE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PD,
        ST_KLO,
        ST_KHI,
        ST_ALPHA,
        ST_SQ,
        ST_S,
        ST_DEN,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_MAC,
        ST_FIN
    } t_state;

endpackage

@@ src/bwlf_in_if.sv @@
// input sample channel of the filter unit
// depends on bwlf_pkg
interface bwlf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bwlf_pkg::SAMPLE_W-1:0] sample;
    logic        [bwlf_pkg::DT_W-1:0]     elapsed_us;

    modport source (output valid, output sample, output elapsed_us, input ready);
    modport sink   (input valid, input sample, input elapsed_us, output ready);
endinterface

@@ src/bwlf_out_if.sv @@
// filtered sample channel of the filter unit
// depends on bwlf_pkg
interface bwlf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bwlf_pkg::SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

@@ src/bwlf_div.sv @@
// restoring divider, one quotient bit per cycle: round(mag * 2^30 / den)
// depends on bwlf_pkg
module bwlf_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [bwlf_pkg::WIDE_W-1:0]      i_mag,
    input  logic [bwlf_pkg::WIDE_W-1:0]      i_den,
    output logic                             o_done,
    output logic [bwlf_pkg::COEF_W-1:0]      o_quot
);
    logic                            r_busy;
    logic [bwlf_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [bwlf_pkg::WIDE_W-1:0]     r_rem;
    logic [bwlf_pkg::WIDE_W-1:0]     r_den;
    logic [31:0]                     r_nlo;
    logic [bwlf_pkg::COEF_W-1:0]     r_quot;
    logic [93:0]                     num;
    logic [63:0]                     trial;
    logic                            qbit;

    // numerator with half the divisor added for round to nearest
    assign num   = {1'b0, i_mag, 30'b0} + {32'b0, i_den[bwlf_pkg::WIDE_W-1:1]};
    assign trial = {r_rem, r_nlo[31]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= bwlf_pkg::DIV_CNT_W'(bwlf_pkg::DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, num[93:32]};
            r_nlo  <= num[31:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem  <= qbit ? bwlf_pkg::WIDE_W'(trial - {1'b0, r_den})
                           : trial[bwlf_pkg::WIDE_W-1:0];
            r_nlo  <= {r_nlo[30:0], 1'b0};
            r_quot <= {r_quot[bwlf_pkg::COEF_W-2:0], qbit};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quot;
endmodule

@@ src/butterworth_lowpass_filter_unit.sv @@
// top level of the butterworth low-pass filter unit, first or second order
// depends on bwlf_pkg, bwlf_in_if, bwlf_out_if, bwlf_div
//
//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | sample (s16), elapsed_us (u20)
//  o_out    | out | valid / ready | filtered (s16)
//  i_cfg_*  | in  | write enable  | index (2), data (24)
//
// the coefficients take three divisions at order 2 and two at order 1, all on the
// one-bit-per-cycle divider
// reset is synchronous active low; it restores the config defaults and clears
// the histories, the output valid and the fsm
// one item in flight; a finished sample waits in the output register, and a
// stalled output holds the next item only in its final state
module butterworth_lowpass_filter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bwlf_in_if.sink                            i_in,
    bwlf_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [bwlf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bwlf_pkg::CFG_W-1:0]         i_cfg_data
);
    bwlf_pkg::t_state r_state, n_state;

    // configuration
    logic [bwlf_pkg::ORD_W-1:0] r_order;
    logic                       r_adaptive;
    logic [bwlf_pkg::CUT_W-1:0] r_cutoff;
    logic [bwlf_pkg::DT_W-1:0]  r_period;

    // histories and current item
    logic signed [bwlf_pkg::SAMPLE_W-1:0] r_x0, r_x1, r_x2;
    logic signed [bwlf_pkg::HIST_W-1:0]   r_y1, r_y2;
    logic [bwlf_pkg::DT_W-1:0]            r_dt;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;
    logic        mul_neg;
    logic        r_psign;

    // coefficient work
    logic [11:0]                  r_phi;
    logic [bwlf_pkg::WIDE_W-1:0]  r_plo_k;
    logic [bwlf_pkg::ALPHA_W-1:0] r_alpha;
    logic [61:0]                  r_a2;
    logic [48:0]                  r_s;
    logic [bwlf_pkg::WIDE_W-1:0]  r_den;
    logic [1:0]                   r_div_idx;
    logic [bwlf_pkg::COEF_W-1:0]  r_b0, r_a0_mag, r_a1_mag;
    logic                         r_a0_neg;
    logic                         r_num_neg;
    logic [2:0]                   r_mac_idx;
    logic signed [bwlf_pkg::ACC_W-1:0] r_acc;

    // output register
    logic                                 r_out_valid;
    logic signed [bwlf_pkg::SAMPLE_W-1:0] r_out_data;

    logic ord1;
    logic in_xfer, out_xfer;
    logic fin_go;

    logic [75:0]                  alpha_tot;
    logic [bwlf_pkg::ALPHA_W-1:0] alpha_c;
    logic [48:0]                  s_c;
    logic [bwlf_pkg::WIDE_W-1:0]  two_a2, a2_four, num_mag;
    logic                         num_neg;
    logic                         div_start, div_done;
    logic [bwlf_pkg::COEF_W-1:0]  div_quot;
    logic                         last_div;

    logic [bwlf_pkg::COEF_W-1:0]  c_mag;
    logic                         c_neg;
    logic [31:0]                  d_mag;
    logic                         d_neg;
    logic [16:0]                  xm;
    logic signed [bwlf_pkg::SAMPLE_W-1:0] xsel;
    logic signed [bwlf_pkg::HIST_W-1:0]   ysel;
    logic [32:0]                  ym;
    logic signed [bwlf_pkg::ACC_W-1:0] term;
    logic signed [bwlf_pkg::ACC_W-1:0] acc_r;
    logic signed [37:0]           y_sh;
    logic signed [bwlf_pkg::HIST_W-1:0] y0;
    logic signed [32:0]           y_rnd;
    logic signed [16:0]           f_sh;
    logic signed [bwlf_pkg::SAMPLE_W-1:0] f_sat;

    assign ord1     = (r_order == bwlf_pkg::ORDER_ONE);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;
    assign fin_go   = !r_out_valid || o_out.ready;
    assign last_div = ord1 ? (r_div_idx == 2'd1) : (r_div_idx == 2'd2);

    assign i_in.ready     = (r_state == bwlf_pkg::ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.filtered = r_out_data;

    // config writes, masked to register widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= 2'd2;
            r_adaptive <= 1'b0;
            r_cutoff   <= bwlf_pkg::CUT_W'(2560);
            r_period   <= bwlf_pkg::DT_W'(1000);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bwlf_pkg::CFG_ORDER:    r_order    <= i_cfg_data[bwlf_pkg::ORD_W-1:0];
                bwlf_pkg::CFG_ADAPTIVE: r_adaptive <= i_cfg_data[0];
                bwlf_pkg::CFG_CUTOFF:   r_cutoff   <= i_cfg_data;
                bwlf_pkg::CFG_PERIOD:   r_period   <= i_cfg_data[bwlf_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

    // alpha = round(cutoff * dt * k / 2^40), saturated
    assign alpha_tot = {13'b0, r_plo_k} + {r_prod[43:0], 32'b0} + (76'd1 << 39);
    assign alpha_c   = (|alpha_tot[75:71]) ? {bwlf_pkg::ALPHA_W{1'b1}} : alpha_tot[70:40];

    // s = round(alpha * 2*sqrt(2)) in q17.32
    assign s_c = 49'((r_prod[62:0] + 63'd8192) >> 14);

    // numerators of the coefficient quotients
    assign two_a2  = {r_a2, 1'b0};
    assign a2_four = {1'b0, r_a2} + (63'd4 << 32);

    always_comb begin
        num_mag = '0;
        num_neg = 1'b0;
        case (r_div_idx)
            2'd0: begin
                num_mag = ord1 ? {32'b0, r_alpha} : {1'b0, r_a2};
            end
            2'd1: begin
                if (ord1) begin
                    if ({32'b0, r_alpha} <= (63'd2 << 16)) begin
                        num_mag = (63'd2 << 16) - {32'b0, r_alpha};
                    end else begin
                        num_mag = {32'b0, r_alpha} - (63'd2 << 16);
                        num_neg = 1'b1;
                    end
                end else begin
                    if (two_a2 <= (63'd8 << 32)) begin
                        num_mag = (63'd8 << 32) - two_a2;
                    end else begin
                        num_mag = two_a2 - (63'd8 << 32);
                        num_neg = 1'b1;
                    end
                end
            end
            2'd2: begin
                num_mag = (a2_four >= {14'b0, r_s}) ? a2_four - {14'b0, r_s} : '0;
                num_neg = 1'b1;
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == bwlf_pkg::ST_DIV_GO);

    bwlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (num_mag),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // operands of the mac terms: b0*x0, b1*x1, b2*x2, a0*y1, a1*y2
    always_comb begin
        c_mag = '0;
        c_neg = 1'b0;
        xsel  = r_x0;
        ysel  = r_y1;
        case (r_mac_idx)
            3'd0: begin
                c_mag = r_b0;
                xsel  = r_x0;
            end
            3'd1: begin
                c_mag = ord1 ? r_b0 : {r_b0[bwlf_pkg::COEF_W-2:0], 1'b0};
                xsel  = r_x1;
            end
            3'd2: begin
                c_mag = ord1 ? '0 : r_b0;
                xsel  = r_x2;
            end
            3'd3: begin
                c_mag = r_a0_mag;
                c_neg = r_a0_neg;
                ysel  = r_y1;
            end
            3'd4: begin
                c_mag = ord1 ? '0 : r_a1_mag;
                c_neg = 1'b1;
                ysel  = r_y2;
            end
            default: ;
        endcase
    end

    assign xm = xsel[bwlf_pkg::SAMPLE_W-1] ? 17'(-{xsel[bwlf_pkg::SAMPLE_W-1], xsel})
                                           : {1'b0, xsel};
    assign ym = ysel[bwlf_pkg::HIST_W-1] ? 33'(-{ysel[bwlf_pkg::HIST_W-1], ysel})
                                         : {1'b0, ysel};

    always_comb begin
        if (r_mac_idx >= 3'd3) begin
            d_mag = ym[31:0];
            d_neg = ysel[bwlf_pkg::HIST_W-1];
        end else begin
            d_mag = {xm[15:0], 16'b0};
            d_neg = xsel[bwlf_pkg::SAMPLE_W-1];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (r_state)
            bwlf_pkg::ST_PD: begin
                mul_a = {8'b0, r_cutoff};
                mul_b = {12'b0, r_dt};
            end
            bwlf_pkg::ST_KLO: begin
                mul_a = r_prod[31:0];
                mul_b = bwlf_pkg::ALPHA_K;
            end
            bwlf_pkg::ST_KHI: begin
                mul_a = {20'b0, r_phi};
                mul_b = bwlf_pkg::ALPHA_K;
            end
            bwlf_pkg::ST_SQ: begin
                mul_a = {1'b0, r_alpha};
                mul_b = {1'b0, r_alpha};
            end
            bwlf_pkg::ST_S: begin
                mul_a = {1'b0, r_alpha};
                mul_b = bwlf_pkg::TWO_SQRT2_Q30;
            end
            bwlf_pkg::ST_MAC: begin
                mul_a   = c_mag;
                mul_b   = d_mag;
                mul_neg = c_neg ^ d_neg;
            end
            default: ;
        endcase
    end

    // signed term from the previous product
    assign term = r_psign ? -$signed({4'b0, r_prod}) : $signed({4'b0, r_prod});

    // round to q.16 and saturate to 32 bits
    assign acc_r = r_acc + (68'sd1 <<< 29);
    assign y_sh  = acc_r[67:30];
    always_comb begin
        if (y_sh > 38'sh0_7FFF_FFFF) begin
            y0 = 32'sh7FFF_FFFF;
        end else if (y_sh < -38'sh0_8000_0000) begin
            y0 = -32'sh8000_0000;
        end else begin
            y0 = y_sh[31:0];
        end
    end

    // sample out: (y + 0x8000) >> 16, clamped high
    assign y_rnd = {y0[31], y0} + 33'sd32768;
    assign f_sh  = y_rnd[32:16];
    assign f_sat = (f_sh > 17'sd32767) ? 16'sh7FFF : f_sh[15:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bwlf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bwlf_pkg::ST_IDLE:    if (in_xfer) n_state = bwlf_pkg::ST_PD;
            bwlf_pkg::ST_PD:      n_state = bwlf_pkg::ST_KLO;
            bwlf_pkg::ST_KLO:     n_state = bwlf_pkg::ST_KHI;
            bwlf_pkg::ST_KHI:     n_state = bwlf_pkg::ST_ALPHA;
            bwlf_pkg::ST_ALPHA:   n_state = ord1 ? bwlf_pkg::ST_DIV_GO : bwlf_pkg::ST_SQ;
            bwlf_pkg::ST_SQ:      n_state = bwlf_pkg::ST_S;
            bwlf_pkg::ST_S:       n_state = bwlf_pkg::ST_DEN;
            bwlf_pkg::ST_DEN:     n_state = bwlf_pkg::ST_DIV_GO;
            bwlf_pkg::ST_DIV_GO:  n_state = bwlf_pkg::ST_DIV_RUN;
            bwlf_pkg::ST_DIV_RUN: begin
                if (div_done) begin
                    n_state = last_div ? bwlf_pkg::ST_MAC : bwlf_pkg::ST_DIV_GO;
                end
            end
            bwlf_pkg::ST_MAC:     if (r_mac_idx == 3'd5) n_state = bwlf_pkg::ST_FIN;
            bwlf_pkg::ST_FIN:     if (fin_go) n_state = bwlf_pkg::ST_IDLE;
            default:              n_state = bwlf_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod  <= {32'b0, mul_a} * {32'b0, mul_b};
        r_psign <= mul_neg;
        case (r_state)
            bwlf_pkg::ST_IDLE: begin
                r_x0      <= i_in.sample;
                r_dt      <= r_adaptive ? i_in.elapsed_us : r_period;
                r_div_idx <= '0;
                r_mac_idx <= '0;
                r_acc     <= '0;
            end
            bwlf_pkg::ST_KLO:  r_phi   <= r_prod[43:32];
            bwlf_pkg::ST_KHI:  r_plo_k <= r_prod[62:0];
            bwlf_pkg::ST_ALPHA: begin
                r_alpha <= alpha_c;
                r_den   <= {32'b0, alpha_c} + (63'd2 << 16);
            end
            bwlf_pkg::ST_S:    r_a2 <= r_prod[61:0];
            bwlf_pkg::ST_DEN: begin
                r_s   <= s_c;
                r_den <= {1'b0, r_a2} + {14'b0, s_c} + (63'd4 << 32);
            end
            bwlf_pkg::ST_DIV_GO: r_num_neg <= num_neg;
            bwlf_pkg::ST_DIV_RUN: begin
                if (div_done) begin
                    case (r_div_idx)
                        2'd0: r_b0 <= div_quot;
                        2'd1: begin
                            r_a0_mag <= div_quot;
                            r_a0_neg <= r_num_neg;
                        end
                        default: r_a1_mag <= div_quot;
                    endcase
                    r_div_idx <= r_div_idx + 1'b1;
                end
            end
            bwlf_pkg::ST_MAC: begin
                if (r_mac_idx != 3'd0) begin
                    r_acc <= r_acc + term;
                end
                r_mac_idx <= r_mac_idx + 1'b1;
            end
            default: ;
        endcase
    end

    // histories clear at reset and shift once per finished item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (r_state == bwlf_pkg::ST_FIN && fin_go) begin
            r_x2 <= r_x1;
            r_x1 <= r_x0;
            r_y2 <= r_y1;
            r_y1 <= y0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bwlf_pkg::ST_FIN && fin_go) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bwlf_pkg::ST_FIN && fin_go) begin
            r_out_data <= f_sat;
        end
    end
endmodule

@@ src/bwlf_checker.sv @@
// port-level checks of the butterworth low-pass filter unit, bound to the top
// depends on butterworth_lowpass_filter_unit_macros.svh
`include "butterworth_lowpass_filter_unit_macros.svh"

module bwlf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_filtered
);
    // reset empties the output register
    `BWLF_ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // one item at a time: a transfer in closes the input
    `BWLF_ASSERT(a_in_busy, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready right after input transfer")

    // no result appears straight after an input transfer made while the output was empty
    `BWLF_ASSERT(a_no_fast_result, i_clk, i_rst_n, (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid, "result too early")

    // a stalled result holds
    `BWLF_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_filtered)), "stalled output changed")
endmodule

bind butterworth_lowpass_filter_unit bwlf_checker u_bwlf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_filtered (o_out.filtered)
);
